// ----- src/sfs_pkg.sv -----
// Shared types and operation codes for the sprite frame sequencer.
package sfs_pkg;

  localparam logic [2:0] OP_TICK        = 3'd0;
  localparam logic [2:0] OP_SELECT      = 3'd1;
  localparam logic [2:0] OP_PING_PONG   = 3'd2;
  localparam logic [2:0] OP_RESET_COUNT = 3'd3;
  localparam logic [2:0] OP_WRITE_FRAME = 3'd4;
  localparam logic [2:0] OP_WRITE_COUNT = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_TICK,
    S_LOOK,
    S_SHOW
  } state_t;

  typedef struct packed {
    logic load_req;
    logic exec;
    logic tick;
    logic load_out;
  } sfs_cmd_t;

  typedef struct packed {
    logic is_tick;
  } sfs_stat_t;

endpackage

// ----- src/sfs_ram.sv -----
// Generic simple dual-port RAM with a registered read.
module sfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/sfs_ctrl.sv -----
// Controller state machine that sequences one request through the datapath.
module sfs_ctrl import sfs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  sfs_stat_t stat,
  output sfs_cmd_t  cmd
);

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = stat.is_tick ? S_TICK : S_LOOK;
      end
      S_TICK: begin
        cmd.tick   = 1'b1;
        state_next = S_LOOK;
      end
      S_LOOK: begin
        state_next = S_SHOW;
      end
      S_SHOW: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid) |=> (state == S_EXEC))
    else $error("accepted request did not start execution");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> out_free)
    else $error("result loaded over an untaken result");

  a_valid_after_show: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_SHOW))
    else $error("result shown without a lookup");

  a_tick_after_exec: assert property (@(posedge clk) disable iff (rst)
    (state == S_TICK) |-> ($past(state) == S_EXEC))
    else $error("tick step entered out of order");

endmodule

// ----- src/sfs_datapath.sv -----
// Datapath: request registers, frame tables, sequencing state and result register.
module sfs_datapath import sfs_pkg::*; #(
  parameter int MAX_ANIMATIONS = 16,
  parameter int MAX_FRAMES     = 16,
  parameter int TICK_BITS      = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  sfs_cmd_t   cmd,
  output sfs_stat_t  stat,
  input  logic [2:0] operation,
  input  logic [3:0] animation_sel,
  input  logic [3:0] frame_sel,
  input  logic [7:0] sprite_number,
  input  logic [15:0] frame_ticks,
  input  logic [4:0] frame_total,
  output logic [7:0] shown_sprite,
  output logic [3:0] shown_frame,
  output logic [3:0] shown_animation,
  output logic       going_back
);

  localparam int ENTRIES = MAX_ANIMATIONS * MAX_FRAMES;
  localparam int TBL_AW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_AW  = (MAX_ANIMATIONS > 1) ? $clog2(MAX_ANIMATIONS) : 1;
  localparam logic [4:0] FRAMES_CAP = 5'((MAX_FRAMES > 31) ? 31 : MAX_FRAMES);

  logic [2:0]  req_op;
  logic [3:0]  req_anim;
  logic [3:0]  req_frame;
  logic [7:0]  req_sprite;
  logic [15:0] req_ticks;
  logic [4:0]  req_total;

  logic [3:0]           active_animation;
  logic [3:0]           active_frame;
  logic [TICK_BITS-1:0] tick_counter;
  logic                 ping_pong_on;
  logic                 backward_dir;

  logic [3:0]           frame_next;
  logic                 backward_next;
  logic [TICK_BITS-1:0] counter_next;

  logic [31:0] cur_entry;
  logic [31:0] wr_entry;
  logic [31:0] cur_anim_w;
  logic [31:0] req_anim_w;
  logic        anim_ok;
  logic        frame_ok;
  logic        tbl_we;
  logic        cnt_we;
  logic [23:0] tbl_rdata;
  logic [4:0]  cnt_rdata;
  logic [4:0]  eff_count;
  logic [4:0]  step_frame;
  logic        ticks_match;

  assign stat.is_tick = (req_op == OP_TICK);

  assign cur_anim_w = {28'd0, active_animation};
  assign req_anim_w = {28'd0, req_anim};
  assign cur_entry  = cur_anim_w * 32'(MAX_FRAMES) + {28'd0, active_frame};
  assign wr_entry   = req_anim_w * 32'(MAX_FRAMES) + {28'd0, req_frame};
  assign anim_ok    = (req_anim_w < 32'(MAX_ANIMATIONS));
  assign frame_ok   = ({28'd0, req_frame} < 32'(MAX_FRAMES));
  assign tbl_we     = cmd.exec && (req_op == OP_WRITE_FRAME) && anim_ok && frame_ok;
  assign cnt_we     = cmd.exec && (req_op == OP_WRITE_COUNT) && anim_ok;

  sfs_ram #(
    .WIDTH (24),
    .DEPTH (ENTRIES)
  ) u_frame_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (wr_entry[TBL_AW-1:0]),
    .wdata ({req_sprite, req_ticks}),
    .raddr (cur_entry[TBL_AW-1:0]),
    .rdata (tbl_rdata)
  );

  sfs_ram #(
    .WIDTH (5),
    .DEPTH (MAX_ANIMATIONS)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (req_anim_w[CNT_AW-1:0]),
    .wdata (req_total),
    .raddr (cur_anim_w[CNT_AW-1:0]),
    .rdata (cnt_rdata)
  );

  always_comb begin
    if (cnt_rdata == 5'd0) begin
      eff_count = 5'd1;
    end else if ({27'd0, cnt_rdata} > 32'(MAX_FRAMES)) begin
      eff_count = FRAMES_CAP;
    end else begin
      eff_count = cnt_rdata;
    end
  end

  assign step_frame  = {1'b0, active_frame} + 5'd1;
  assign ticks_match = ({{(32-TICK_BITS){1'b0}}, tick_counter} == {16'd0, tbl_rdata[15:0]});

  always_comb begin
    frame_next    = active_frame;
    backward_next = backward_dir;
    counter_next  = tick_counter;
    if (ticks_match) begin
      counter_next = '0;
      if (!ping_pong_on) begin
        frame_next = (step_frame >= eff_count) ? 4'd0 : step_frame[3:0];
      end else if (!backward_dir && ({1'b0, active_frame} >= (eff_count - 5'd1))) begin
        backward_next = 1'b1;
      end else if (backward_dir && (active_frame == 4'd0)) begin
        backward_next = 1'b0;
      end else if (backward_dir) begin
        frame_next = active_frame - 4'd1;
      end else begin
        frame_next = step_frame[3:0];
      end
    end
    counter_next = counter_next + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_op     <= operation;
      req_anim   <= animation_sel;
      req_frame  <= frame_sel;
      req_sprite <= sprite_number;
      req_ticks  <= frame_ticks;
      req_total  <= frame_total;
    end
    if (cmd.load_out) begin
      shown_sprite    <= tbl_rdata[23:16];
      shown_frame     <= active_frame;
      shown_animation <= active_animation;
      going_back      <= backward_dir;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_animation <= '0;
      active_frame     <= '0;
      tick_counter     <= '0;
      ping_pong_on     <= 1'b0;
      backward_dir     <= 1'b0;
    end else if (cmd.tick) begin
      active_frame <= frame_next;
      backward_dir <= backward_next;
      tick_counter <= counter_next;
    end else if (cmd.exec) begin
      case (req_op)
        OP_SELECT: begin
          if (anim_ok && (req_anim != active_animation)) begin
            active_animation <= req_anim;
            ping_pong_on     <= 1'b0;
            active_frame     <= '0;
            tick_counter     <= '0;
          end
        end
        OP_PING_PONG: begin
          ping_pong_on <= 1'b1;
        end
        OP_RESET_COUNT: begin
          tick_counter <= '0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- src/sprite_frame_sequencer.sv -----
// Top level of the sprite frame sequencer: controller, datapath and ports.
//
// Each request is one operation on the animation table or the playback
// state, and every request returns one result with the sprite, frame,
// animation and direction that are current after it. From acceptance, a
// request passes through EXEC, which applies it, TICK, which only a tick
// visits and which advances the frame, LOOK, which waits for the registered
// read of the sprite of the current frame, and SHOW, which loads the result
// once the output register is free. The next request is taken in the cycle
// after its predecessor's result has been loaded, even while that result is
// stalled, but no new request is taken while one is in the datapath. The
// frame and count tables hold unknown contents after reset and must be
// written before they are played.
module sprite_frame_sequencer import sfs_pkg::*; #(
  parameter int MAX_ANIMATIONS = 16,
  parameter int MAX_FRAMES     = 16,
  parameter int TICK_BITS      = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation,
  input  logic [3:0]  animation_sel,
  input  logic [3:0]  frame_sel,
  input  logic [7:0]  sprite_number,
  input  logic [15:0] frame_ticks,
  input  logic [4:0]  frame_total,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  shown_sprite,
  output logic [3:0]  shown_frame,
  output logic [3:0]  shown_animation,
  output logic        going_back
);

  sfs_cmd_t  cmd;
  sfs_stat_t stat;

  sfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  sfs_datapath #(
    .MAX_ANIMATIONS (MAX_ANIMATIONS),
    .MAX_FRAMES     (MAX_FRAMES),
    .TICK_BITS      (TICK_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .operation       (operation),
    .animation_sel   (animation_sel),
    .frame_sel       (frame_sel),
    .sprite_number   (sprite_number),
    .frame_ticks     (frame_ticks),
    .frame_total     (frame_total),
    .shown_sprite    (shown_sprite),
    .shown_frame     (shown_frame),
    .shown_animation (shown_animation),
    .going_back      (going_back)
  );

endmodule

// ----- tb/frame_sequence_checker.sv -----
`timescale 1ns / 100ps
// Checker that predicts and compares every result of the sprite frame sequencer.
module frame_sequence_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  operation,
  input  logic [3:0]  animation_sel,
  input  logic [3:0]  frame_sel,
  input  logic [7:0]  sprite_number,
  input  logic [15:0] frame_ticks,
  input  logic [4:0]  frame_total,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  shown_sprite,
  input  logic [3:0]  shown_frame,
  input  logic [3:0]  shown_animation,
  input  logic        going_back,
  output int          pending,
  output int          errors
);
  import sfs_pkg::*;

  typedef struct packed {
    logic [7:0] sprite;
    logic [3:0] frame;
    logic [3:0] anim;
    logic       back;
  } shown_t;

  logic [7:0]  sprite_mem [16][16];
  logic [15:0] dur_mem [16][16];
  logic [4:0]  len_mem [16];
  logic [3:0]  cur_anim;
  logic [3:0]  cur_frame;
  logic [15:0] tick_cnt;
  logic        pp_mode;
  logic        rev_dir;
  shown_t      shown_q [$];
  int          err_cnt = 0;

  initial pending = 0;
  assign errors = err_cnt;

  task automatic flag_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic shown_t play_request(input logic [2:0] op, input logic [3:0] anim,
                                          input logic [3:0] frm, input logic [7:0] spr,
                                          input logic [15:0] dur, input logic [4:0] total);
    int span;
    case (op)
      OP_TICK: begin
        if (tick_cnt == dur_mem[cur_anim][cur_frame]) begin
          span = int'(len_mem[cur_anim]);
          if (span == 0) span = 1;
          if (span > 16) span = 16;
          tick_cnt = '0;
          if (!pp_mode) cur_frame = (int'(cur_frame) + 1 >= span) ? 4'd0 : cur_frame + 4'd1;
          else if (!rev_dir && int'(cur_frame) >= span - 1) rev_dir = 1'b1;
          else if (rev_dir && cur_frame == 4'd0) rev_dir = 1'b0;
          else if (rev_dir) cur_frame = cur_frame - 4'd1;
          else cur_frame = cur_frame + 4'd1;
        end
        tick_cnt = tick_cnt + 16'd1;
      end
      OP_SELECT: begin
        if (anim != cur_anim) begin
          cur_anim  = anim;
          pp_mode   = 1'b0;
          cur_frame = '0;
          tick_cnt  = '0;
        end
      end
      OP_PING_PONG:   pp_mode = 1'b1;
      OP_RESET_COUNT: tick_cnt = '0;
      OP_WRITE_FRAME: begin
        sprite_mem[anim][frm] = spr;
        dur_mem[anim][frm]    = dur;
      end
      OP_WRITE_COUNT: len_mem[anim] = total;
      default: ;
    endcase
    return '{sprite_mem[cur_anim][cur_frame], cur_frame, cur_anim, rev_dir};
  endfunction

  always @(posedge clk) begin
    shown_t want;
    if (rst) begin
      cur_anim  = '0;
      cur_frame = '0;
      tick_cnt  = '0;
      pp_mode   = 1'b0;
      rev_dir   = 1'b0;
      shown_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (shown_q.size() == 0) begin
          flag_mismatch($sformatf("result with no request pending, sprite %0d frame %0d",
                                  shown_sprite, shown_frame));
        end else begin
          want = shown_q.pop_front();
          if (shown_sprite !== want.sprite)
            flag_mismatch($sformatf("shown_sprite %0d, expected %0d", shown_sprite, want.sprite));
          if (shown_frame !== want.frame)
            flag_mismatch($sformatf("shown_frame %0d, expected %0d", shown_frame, want.frame));
          if (shown_animation !== want.anim)
            flag_mismatch($sformatf("shown_animation %0d, expected %0d",
                                    shown_animation, want.anim));
          if (going_back !== want.back)
            flag_mismatch($sformatf("going_back %0b, expected %0b", going_back, want.back));
        end
      end
      if (in_valid && !in_stall)
        shown_q.push_back(play_request(operation, animation_sel, frame_sel, sprite_number,
                                       frame_ticks, frame_total));
    end
    pending <= shown_q.size();
  end

endmodule

// ----- tb/tb_sprite_frame_sequencer.sv -----
`timescale 1ns / 100ps
// Top of the sprite frame sequencer testbench: clock, reset, stimulus and verdict.
module tb_sprite_frame_sequencer;
  import sfs_pkg::*;

  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int ITEM_TOTAL   = 1050;
  localparam int HOLD_CYCLES  = 150;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  operation = OP_TICK;
  logic [3:0]  animation_sel = '0;
  logic [3:0]  frame_sel = '0;
  logic [7:0]  sprite_number = '0;
  logic [15:0] frame_ticks = '0;
  logic [4:0]  frame_total = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  shown_sprite;
  logic [3:0]  shown_frame;
  logic [3:0]  shown_animation;
  logic        going_back;

  int          pending;
  int          errors;
  int          phase = 0;
  int          quiet_cycles = 0;
  int          n_sent = 0;
  logic        count_known [16];
  logic [15:0] frames_known [16];
  logic [3:0]  now_playing = '0;

  sprite_frame_sequencer u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .operation       (operation),
    .animation_sel   (animation_sel),
    .frame_sel       (frame_sel),
    .sprite_number   (sprite_number),
    .frame_ticks     (frame_ticks),
    .frame_total     (frame_total),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .shown_sprite    (shown_sprite),
    .shown_frame     (shown_frame),
    .shown_animation (shown_animation),
    .going_back      (going_back)
  );

  frame_sequence_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .operation       (operation),
    .animation_sel   (animation_sel),
    .frame_sel       (frame_sel),
    .sprite_number   (sprite_number),
    .frame_ticks     (frame_ticks),
    .frame_total     (frame_total),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .shown_sprite    (shown_sprite),
    .shown_frame     (shown_frame),
    .shown_animation (shown_animation),
    .going_back      (going_back),
    .pending         (pending),
    .errors          (errors)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // An animation may only be played once its count and every frame entry are written.
  function automatic logic ready(input logic [3:0] anim);
    return count_known[anim] && (&frames_known[anim]);
  endfunction

  function automatic logic [15:0] pick_ticks();
    return ($urandom_range(7) == 0) ? 16'($urandom_range(65535)) : 16'($urandom_range(4));
  endfunction

  function automatic logic [4:0] pick_total();
    return ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(1, 16));
  endfunction

  task automatic send(input logic [2:0] op, input logic [3:0] anim, input logic [3:0] frm,
                      input logic [7:0] spr, input logic [15:0] dur, input logic [4:0] total);
    int idle_pct;
    idle_pct = (phase == 0) ? 6 : (phase == 1) ? 57 : 0;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= op;
    animation_sel <= anim;
    frame_sel     <= frm;
    sprite_number <= spr;
    frame_ticks   <= dur;
    frame_total   <= total;
    do @(posedge clk); while (in_stall);
    n_sent++;
    if (op == OP_WRITE_FRAME) frames_known[anim][frm] = 1'b1;
    if (op == OP_WRITE_COUNT) count_known[anim] = 1'b1;
    if (op == OP_SELECT) now_playing = anim;
  endtask

  task automatic send_op(input logic [2:0] op, input logic [3:0] anim);
    send(op, anim, 4'($urandom_range(15)), 8'($urandom_range(255)), 16'($urandom),
         5'($urandom_range(31)));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    logic [3:0] anim;
    int pick;
    for (int i = 0; i < 16; i++) begin
      count_known[i]  = 1'b0;
      frames_known[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Animation 0 is shown right after reset, so its table is filled first.
    for (int f = 0; f < 16; f++)
      send(OP_WRITE_FRAME, 4'd0, 4'(f), 8'(f * 17), (f == 15) ? 16'hFFFF : 16'(f % 3), 5'd0);
    send(OP_WRITE_COUNT, 4'd0, 4'd15, 8'd0, 16'd0, 5'd3);
    repeat (3) send_op(OP_TICK, 4'd0);
    send_op(OP_PING_PONG, 4'd0);
    repeat (4) send_op(OP_TICK, 4'd0);
    send_op(OP_RESET_COUNT, 4'd0);
    send_op(OP_SPARE_LO, 4'd0);
    send_op(OP_SPARE_HI, 4'd15);
    send_op(OP_SELECT, 4'd0);
    drain();

    while (n_sent < ITEM_TOTAL) begin
      if (phase == 0 && n_sent >= ITEM_TOTAL / 3) begin
        drain();
        phase <= 1;
      end else if (phase == 1 && n_sent >= 2 * ITEM_TOTAL / 3) begin
        phase <= 2;
      end
      pick = $urandom_range(99);
      anim = 4'($urandom_range(15));
      if (pick < 6) begin
        send(OP_WRITE_COUNT, anim, 4'($urandom_range(15)), 8'($urandom_range(255)),
             16'($urandom), pick_total());
        for (int f = 0; f < 16; f++)
          send(OP_WRITE_FRAME, anim, 4'(f), 8'($urandom_range(255)), pick_ticks(),
               5'($urandom_range(31)));
        send_op(OP_SELECT, anim);
        if ($urandom_range(1)) send_op(OP_PING_PONG, anim);
        repeat ($urandom_range(4, 20)) send_op(OP_TICK, anim);
      end else if (pick < 18) begin
        send_op(OP_SELECT, ready(anim) ? anim : now_playing);
      end else if (pick < 23) begin
        send_op(OP_PING_PONG, anim);
      end else if (pick < 28) begin
        send_op(OP_RESET_COUNT, anim);
      end else if (pick < 38) begin
        send(OP_WRITE_FRAME, $urandom_range(1) ? now_playing : anim, 4'($urandom_range(15)),
             8'($urandom_range(255)), pick_ticks(), 5'($urandom_range(31)));
      end else if (pick < 45) begin
        send(OP_WRITE_COUNT, $urandom_range(1) ? now_playing : anim, 4'($urandom_range(15)),
             8'($urandom_range(255)), 16'($urandom), pick_total());
      end else if (pick < 48) begin
        send_op($urandom_range(1) ? OP_SPARE_LO : OP_SPARE_HI, anim);
      end else begin
        repeat ($urandom_range(1, 12)) send_op(OP_TICK, anim);
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // In the last phase the receiver holds off once so that the block backs up.
  initial begin
    logic held;
    int stall_pct;
    held = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (phase == 2 && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall_pct = (phase == 0) ? 57 : (phase == 1) ? 6 : 0;
      out_stall <= ($urandom_range(99) < stall_pct);
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
